// ===== rtl/pulse_beat_rate_detector_defines.svh =====
// ----------------------------------------------------------------------------
// Pulse beat rate detector assertion macros
// Shared property wrappers; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH
`define PULSE_BEAT_RATE_DETECTOR_DEFINES_SVH

// Same-cycle implication under reset.
`define PBRD_ASSERT_IMP(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("pbrd same-cycle check failed");

// Next-cycle implication under reset.
`define PBRD_ASSERT_NXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("pbrd next-cycle check failed");

`endif

// ===== rtl/pbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// Pulse beat rate detector package
// Widths, sizes, register indexes, reset values and the configuration type.
// ----------------------------------------------------------------------------
package pbrd_pkg;

    localparam int WINDOW_LEN  = 8;
    localparam int HISTORY_LEN = 4;

    localparam int SAMPLE_W    = 18;
    localparam int TIME_W      = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int GAIN_W      = 9;
    localparam int GAIN_FRAC   = 8;
    localparam int INTERVAL_W  = 12;
    localparam int RATE_W      = 8;

    localparam int WIN_AW      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int WIN_SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN + 1);
    localparam int HIST_AW     = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int HIST_CNT_W  = $clog2(HISTORY_LEN + 1);
    localparam int HIST_SUM_W  = INTERVAL_W + $clog2(HISTORY_LEN + 1);
    localparam int PROD_W      = SAMPLE_W + GAIN_W;
    localparam int THR_W       = PROD_W - GAIN_FRAC;

    localparam int DIV_W       = 16;
    localparam int DIV_CNT_W   = $clog2(DIV_W);

    localparam logic [DIV_W-1:0]  RATE_NUM = 16'd60000;
    localparam logic [RATE_W-1:0] RATE_MAX = 8'd255;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORTEST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONGEST  = 3'd4;

    localparam logic [SAMPLE_W-1:0]   RST_PRESENCE = 18'd50000;
    localparam logic [TIMEOUT_W-1:0]  RST_TIMEOUT  = 16'd2000;
    localparam logic [GAIN_W-1:0]     RST_GAIN     = 9'd261;
    localparam logic [INTERVAL_W-1:0] RST_SHORTEST = 12'd300;
    localparam logic [INTERVAL_W-1:0] RST_LONGEST  = 12'd1500;

    typedef struct packed {
        logic [SAMPLE_W-1:0]   presence_level;
        logic [TIMEOUT_W-1:0]  beat_timeout_ms;
        logic [GAIN_W-1:0]     threshold_gain;
        logic [INTERVAL_W-1:0] shortest_interval_ms;
        logic [INTERVAL_W-1:0] longest_interval_ms;
    } pbrd_cfg_t;

endpackage

// ===== rtl/pbrd_if.sv =====
// ----------------------------------------------------------------------------
// Pulse beat rate detector channel interfaces
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface pbrd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [pbrd_pkg::SAMPLE_W-1:0] ir_sample;
    logic [pbrd_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output ir_sample, output now_ms, input ready);
    modport sink   (input valid, input ir_sample, input now_ms, output ready);
endinterface

interface pbrd_result_if;
    logic                        valid;
    logic                        ready;
    logic [pbrd_pkg::RATE_W-1:0] beats_per_minute;
    logic                        beat_found;
    logic                        finger_absent;
    logic                        beat_timed_out;

    modport source (output valid, output beats_per_minute, output beat_found,
                    output finger_absent, output beat_timed_out, input ready);
    modport sink   (input valid, input beats_per_minute, input beat_found,
                    input finger_absent, input beat_timed_out, output ready);
endinterface

interface pbrd_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pbrd_pkg::CFG_IDX_W-1:0]  index;
    logic [pbrd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pbrd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Pulse beat rate detector configuration registers
// Decodes register write transactions into the configuration struct.
// ----------------------------------------------------------------------------
module pbrd_cfg_regs (
    input  logic                 clk,
    input  logic                 rst_n,
    pbrd_cfg_if.sink             cfg,
    output pbrd_pkg::pbrd_cfg_t  cfg_val
);

    pbrd_pkg::pbrd_cfg_t cfg_reg;
    pbrd_pkg::pbrd_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_val   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                pbrd_pkg::CFG_PRESENCE:
                    cfg_next.presence_level = cfg.data[pbrd_pkg::SAMPLE_W-1:0];
                pbrd_pkg::CFG_TIMEOUT:
                    cfg_next.beat_timeout_ms = cfg.data[pbrd_pkg::TIMEOUT_W-1:0];
                pbrd_pkg::CFG_GAIN:
                    cfg_next.threshold_gain = cfg.data[pbrd_pkg::GAIN_W-1:0];
                pbrd_pkg::CFG_SHORTEST:
                    cfg_next.shortest_interval_ms = cfg.data[pbrd_pkg::INTERVAL_W-1:0];
                pbrd_pkg::CFG_LONGEST:
                    cfg_next.longest_interval_ms = cfg.data[pbrd_pkg::INTERVAL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.presence_level       <= pbrd_pkg::RST_PRESENCE;
            cfg_reg.beat_timeout_ms      <= pbrd_pkg::RST_TIMEOUT;
            cfg_reg.threshold_gain       <= pbrd_pkg::RST_GAIN;
            cfg_reg.shortest_interval_ms <= pbrd_pkg::RST_SHORTEST;
            cfg_reg.longest_interval_ms  <= pbrd_pkg::RST_LONGEST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/pbrd_divider.sv =====
// ----------------------------------------------------------------------------
// Pulse beat rate detector divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbrd_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pbrd_pkg::DIV_W-1:0] dividend,
    input  logic [pbrd_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [pbrd_pkg::DIV_W-1:0] quotient
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [pbrd_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [pbrd_pkg::DIV_W-1:0]     rem_reg, rem_next;
    logic [pbrd_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [pbrd_pkg::DIV_W-1:0]     dvs_reg, dvs_next;
    logic [pbrd_pkg::DIV_W:0]       shifted;
    logic [pbrd_pkg::DIV_W:0]       diff;
    logic                           fits;

    // The dividend shifts out of the quotient register into the remainder.
    assign shifted = {rem_reg, quo_reg[pbrd_pkg::DIV_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = pbrd_pkg::DIV_CNT_W'(pbrd_pkg::DIV_W - 1);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[pbrd_pkg::DIV_W-1:0] : shifted[pbrd_pkg::DIV_W-1:0];
            quo_next = {quo_reg[pbrd_pkg::DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

// ===== rtl/pulse_beat_rate_detector.sv =====
// ----------------------------------------------------------------------------
// Pulse beat rate detector. With no finger or a stale beat, S_EVAL goes
// straight to S_OUT; else S_THR and S_CMP follow, then S_DIV1 if an interval
// is recorded and S_DIV2 unless the mean interval is zero (two 16-step shared
// divisions). One sample at a time; S_OUT waits while a result is unread.
// Reset restores register defaults and clears control and valid-bit state.
// ----------------------------------------------------------------------------
`include "pulse_beat_rate_detector_defines.svh"

module pulse_beat_rate_detector (
    input  logic        clk,
    input  logic        rst_n,
    pbrd_sample_if.sink sample_in,
    pbrd_result_if.source result_out,
    pbrd_cfg_if.sink    cfg
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EVAL = 7'b0000010,
        S_THR  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_DIV1 = 7'b0010000,
        S_DIV2 = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    pbrd_pkg::pbrd_cfg_t cfg_val;

    logic [pbrd_pkg::SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [pbrd_pkg::TIME_W-1:0]     now_reg, now_next;

    // Sample window memory with per-entry valid bits and a running sum.
    logic [pbrd_pkg::SAMPLE_W-1:0]   win_mem [pbrd_pkg::WINDOW_LEN];
    logic [pbrd_pkg::SAMPLE_W-1:0]   win_rd_reg;
    logic                            win_we;
    logic [pbrd_pkg::WINDOW_LEN-1:0] win_valid_reg, win_valid_next;
    logic [pbrd_pkg::WIN_AW-1:0]     wptr_reg, wptr_next;
    logic [pbrd_pkg::WIN_SUM_W-1:0]  win_sum_reg, win_sum_next;

    // Interval history memory with a running total.
    logic [pbrd_pkg::INTERVAL_W-1:0] hist_mem [pbrd_pkg::HISTORY_LEN];
    logic [pbrd_pkg::INTERVAL_W-1:0] hist_rd_reg;
    logic                            hist_we;
    logic [pbrd_pkg::HIST_AW-1:0]    hptr_reg, hptr_next;
    logic [pbrd_pkg::HIST_CNT_W-1:0] hcnt_reg, hcnt_next;
    logic [pbrd_pkg::HIST_SUM_W-1:0] hist_sum_reg, hist_sum_next;

    logic                            above_reg, above_next;
    logic                            beat_valid_reg, beat_valid_next;
    logic [pbrd_pkg::TIME_W-1:0]     last_beat_reg, last_beat_next;
    logic [pbrd_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic [pbrd_pkg::PROD_W-1:0]     prod_reg, prod_next;
    logic                            found_reg, found_next;
    logic                            absent_reg, absent_next;
    logic                            tmo_reg, tmo_next;

    logic                            out_valid_reg, out_valid_next;
    logic [pbrd_pkg::RATE_W-1:0]     out_bpm_reg, out_bpm_next;
    logic                            out_found_reg, out_found_next;
    logic                            out_absent_reg, out_absent_next;
    logic                            out_tmo_reg, out_tmo_next;

    logic                            div_start;
    logic [pbrd_pkg::DIV_W-1:0]      div_dividend;
    logic [pbrd_pkg::DIV_W-1:0]      div_divisor;
    logic                            div_done;
    logic [pbrd_pkg::DIV_W-1:0]      div_quo;

    logic [pbrd_pkg::TIME_W-1:0]     elapsed;
    logic [pbrd_pkg::SAMPLE_W-1:0]   old_sample;
    logic [pbrd_pkg::SAMPLE_W-1:0]   win_avg;
    logic [pbrd_pkg::THR_W-1:0]      thr;
    logic [pbrd_pkg::THR_W-1:0]      sample_wide;
    logic                            interval_ok;
    logic                            hist_full;
    logic                            out_load;

    pbrd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    pbrd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign sample_in.ready             = (state_reg == S_IDLE);
    assign result_out.valid            = out_valid_reg;
    assign result_out.beats_per_minute = out_bpm_reg;
    assign result_out.beat_found       = out_found_reg;
    assign result_out.finger_absent    = out_absent_reg;
    assign result_out.beat_timed_out   = out_tmo_reg;

    assign elapsed     = now_reg - last_beat_reg;
    assign old_sample  = win_valid_reg[wptr_reg] ? win_rd_reg : '0;
    assign win_avg     = pbrd_pkg::SAMPLE_W'(win_sum_reg / pbrd_pkg::WINDOW_LEN);
    assign thr         = pbrd_pkg::THR_W'(prod_reg >> pbrd_pkg::GAIN_FRAC);
    assign sample_wide = pbrd_pkg::THR_W'(sample_reg);
    assign interval_ok = beat_valid_reg
                      && (elapsed >= pbrd_pkg::TIME_W'(cfg_val.shortest_interval_ms))
                      && (elapsed <= pbrd_pkg::TIME_W'(cfg_val.longest_interval_ms));
    assign hist_full   = (hcnt_reg == pbrd_pkg::HIST_CNT_W'(pbrd_pkg::HISTORY_LEN));
    assign out_load    = (state_reg == S_OUT) && (!out_valid_reg || result_out.ready);

    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        now_next        = now_reg;
        win_we          = 1'b0;
        win_valid_next  = win_valid_reg;
        wptr_next       = wptr_reg;
        win_sum_next    = win_sum_reg;
        hist_we         = 1'b0;
        hptr_next       = hptr_reg;
        hcnt_next       = hcnt_reg;
        hist_sum_next   = hist_sum_reg;
        above_next      = above_reg;
        beat_valid_next = beat_valid_reg;
        last_beat_next  = last_beat_reg;
        rate_next       = rate_reg;
        prod_next       = prod_reg;
        found_next      = found_reg;
        absent_next     = absent_reg;
        tmo_next        = tmo_reg;
        div_start       = 1'b0;
        div_dividend    = '0;
        div_divisor     = '0;
        out_valid_next  = out_valid_reg && !result_out.ready;
        out_bpm_next    = out_bpm_reg;
        out_found_next  = out_found_reg;
        out_absent_next = out_absent_reg;
        out_tmo_next    = out_tmo_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_in.valid)
                begin
                    sample_next = sample_in.ir_sample;
                    now_next    = sample_in.now_ms;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                found_next  = 1'b0;
                absent_next = 1'b0;
                tmo_next    = 1'b0;
                if (sample_reg < cfg_val.presence_level)
                begin
                    // No finger: drop the window and every beat record.
                    win_valid_next  = '0;
                    wptr_next       = '0;
                    win_sum_next    = '0;
                    hptr_next       = '0;
                    hcnt_next       = '0;
                    hist_sum_next   = '0;
                    above_next      = 1'b0;
                    beat_valid_next = 1'b0;
                    last_beat_next  = '0;
                    rate_next       = '0;
                    absent_next     = 1'b1;
                    state_next      = S_OUT;
                end
                else if (beat_valid_reg
                         && (elapsed > pbrd_pkg::TIME_W'(cfg_val.beat_timeout_ms)))
                begin
                    // Stale beat: the window survives, the beat state does not.
                    hptr_next       = '0;
                    hcnt_next       = '0;
                    hist_sum_next   = '0;
                    above_next      = 1'b0;
                    beat_valid_next = 1'b0;
                    last_beat_next  = '0;
                    rate_next       = '0;
                    tmo_next        = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    win_we                   = 1'b1;
                    win_valid_next[wptr_reg] = 1'b1;
                    win_sum_next = win_sum_reg - pbrd_pkg::WIN_SUM_W'(old_sample)
                                 + pbrd_pkg::WIN_SUM_W'(sample_reg);
                    wptr_next = (wptr_reg == pbrd_pkg::WIN_AW'(pbrd_pkg::WINDOW_LEN - 1))
                              ? '0 : wptr_reg + 1'b1;
                    state_next = S_THR;
                end
            end
            S_THR:
            begin
                prod_next  = pbrd_pkg::PROD_W'(win_avg)
                           * pbrd_pkg::PROD_W'(cfg_val.threshold_gain);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_OUT;
                if (!above_reg && (sample_wide > thr))
                begin
                    above_next      = 1'b1;
                    last_beat_next  = now_reg;
                    beat_valid_next = 1'b1;
                    if (interval_ok)
                    begin
                        hist_we    = 1'b1;
                        found_next = 1'b1;
                        hptr_next  = (hptr_reg == pbrd_pkg::HIST_AW'(pbrd_pkg::HISTORY_LEN - 1))
                                   ? '0 : hptr_reg + 1'b1;
                        // Below full, the pointer equals the count, so the
                        // slot being written holds no counted interval yet.
                        if (hist_full)
                        begin
                            hist_sum_next = hist_sum_reg
                                          - pbrd_pkg::HIST_SUM_W'(hist_rd_reg)
                                          + pbrd_pkg::HIST_SUM_W'(elapsed[pbrd_pkg::INTERVAL_W-1:0]);
                        end
                        else
                        begin
                            hist_sum_next = hist_sum_reg
                                          + pbrd_pkg::HIST_SUM_W'(elapsed[pbrd_pkg::INTERVAL_W-1:0]);
                            hcnt_next     = hcnt_reg + 1'b1;
                        end
                        div_start    = 1'b1;
                        div_dividend = pbrd_pkg::DIV_W'(hist_sum_next);
                        div_divisor  = pbrd_pkg::DIV_W'(hcnt_next);
                        state_next   = S_DIV1;
                    end
                end
                else if (above_reg && (sample_wide < thr))
                begin
                    above_next = 1'b0;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    if (div_quo == '0)
                    begin
                        rate_next  = pbrd_pkg::RATE_MAX;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = pbrd_pkg::RATE_NUM;
                        div_divisor  = div_quo;
                        state_next   = S_DIV2;
                    end
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    rate_next  = (div_quo > pbrd_pkg::DIV_W'(pbrd_pkg::RATE_MAX))
                               ? pbrd_pkg::RATE_MAX : div_quo[pbrd_pkg::RATE_W-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_bpm_next    = rate_reg;
                    out_found_next  = found_reg;
                    out_absent_next = absent_reg;
                    out_tmo_next    = tmo_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            win_valid_reg  <= '0;
            wptr_reg       <= '0;
            win_sum_reg    <= '0;
            hptr_reg       <= '0;
            hcnt_reg       <= '0;
            hist_sum_reg   <= '0;
            above_reg      <= 1'b0;
            beat_valid_reg <= 1'b0;
            last_beat_reg  <= '0;
            rate_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            win_valid_reg  <= win_valid_next;
            wptr_reg       <= wptr_next;
            win_sum_reg    <= win_sum_next;
            hptr_reg       <= hptr_next;
            hcnt_reg       <= hcnt_next;
            hist_sum_reg   <= hist_sum_next;
            above_reg      <= above_next;
            beat_valid_reg <= beat_valid_next;
            last_beat_reg  <= last_beat_next;
            rate_reg       <= rate_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        now_reg        <= now_next;
        prod_reg       <= prod_next;
        found_reg      <= found_next;
        absent_reg     <= absent_next;
        tmo_reg        <= tmo_next;
        out_bpm_reg    <= out_bpm_next;
        out_found_reg  <= out_found_next;
        out_absent_reg <= out_absent_next;
        out_tmo_reg    <= out_tmo_next;
    end

    // The pointers do not move between accept and use, so the registered
    // read data always belongs to the entry about to be replaced.
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[wptr_reg] <= sample_reg;
        end
        win_rd_reg <= win_mem[wptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hptr_reg] <= elapsed[pbrd_pkg::INTERVAL_W-1:0];
        end
        hist_rd_reg <= hist_mem[hptr_reg];
    end

    `PBRD_ASSERT_IMP(a_absent_zero_rate, out_valid_reg && out_absent_reg, out_bpm_reg == '0)
    `PBRD_ASSERT_IMP(a_found_nonzero_rate, out_valid_reg && out_found_reg, out_bpm_reg != '0)
    `PBRD_ASSERT_IMP(a_single_flag, out_valid_reg,
        $countones({out_found_reg, out_absent_reg, out_tmo_reg}) <= 1)
    `PBRD_ASSERT_NXT(a_load_shows, out_load, out_valid_reg && (state_reg == S_IDLE))

endmodule
